// ===== rtl/core/rwc_pkg.sv =====
// Shared types and constants for the replay window checker.
`default_nettype none
package rwc_pkg;

	localparam int SLOT_LOG2    = 6;
	localparam int WINDOW_SLOTS = 1 << SLOT_LOG2;
	localparam int CTR_W        = 64;
	localparam int LEN_W        = 17;
	localparam int STAT_W       = 32;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 3;

	localparam logic [LEN_W-1:0] MIN_SEALED_LEN = LEN_W'(24);

	typedef enum logic [1:0] {
		VERDICT_ACCEPT  = 2'd0,
		VERDICT_TOO_OLD = 2'd1,
		VERDICT_DUP     = 2'd2,
		VERDICT_AUTH    = 2'd3
	} verdict_t;

	typedef enum logic {
		REQ_CHECK = 1'b0,
		REQ_CLEAR = 1'b1
	} req_t;

	typedef enum logic {
		REG_CHANNEL_ACTIVE = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic inc_replay;
		logic inc_auth;
		logic inc_accept;
	} stat_upd_t;

endpackage
`default_nettype wire

// ===== rtl/core/rwc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rwc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rwc_apb_regs.sv =====
// APB configuration register block for the replay window checker.
`default_nettype none
module rwc_apb_regs import rwc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output      logic [APB_DATA_W-1:0] prdata,
	output      logic                  pready,
	output      logic                  channel_active
);

	logic     active_q;
	logic     wr_en;
	reg_idx_t reg_idx;
	logic     in_range;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite;
	assign reg_idx  = reg_idx_t'(paddr[2]);
	assign in_range = (reg_idx == REG_CHANNEL_ACTIVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (wr_en && in_range) begin
			active_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (in_range) begin
			prdata = {{(APB_DATA_W-1){1'b0}}, active_q};
		end
	end

	assign channel_active = active_q;

endmodule
`default_nettype wire

// ===== rtl/core/rwc_stats.sv =====
// Saturating statistics counters for the replay window checker.
`default_nettype none
module rwc_stats import rwc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stat_upd_t         upd,
	output      logic [STAT_W-1:0] replay_cnt,
	output      logic [STAT_W-1:0] auth_cnt,
	output      logic [STAT_W-1:0] accept_cnt
);

	logic [STAT_W-1:0] replay_q;
	logic [STAT_W-1:0] auth_q;
	logic [STAT_W-1:0] accept_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replay_q <= '0;
			auth_q   <= '0;
			accept_q <= '0;
		end else begin
			if (upd.inc_replay && (replay_q != '1)) begin
				replay_q <= replay_q + STAT_W'(1);
			end
			if (upd.inc_auth && (auth_q != '1)) begin
				auth_q <= auth_q + STAT_W'(1);
			end
			if (upd.inc_accept && (accept_q != '1)) begin
				accept_q <= accept_q + STAT_W'(1);
			end
		end
	end

	assign replay_cnt = replay_q;
	assign auth_cnt   = auth_q;
	assign accept_cnt = accept_q;

endmodule
`default_nettype wire

// ===== rtl/core/replay_window_checker_top.sv =====
// Top level of the replay window checker: slot RAM control and verdict logic.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  config   | in        | APB psel/penable   | paddr, pwdata, prdata (channel_active)
//  request  | in        | in_valid/in_stall  | req_type, packet_counter, sealed_length, auth_ok
//  result   | out       | out_valid/out_stall| verdict, replays_rejected, auth_failures,
//           |           |                    | packets_opened
//
// For each beat the slot RAM is read in the accept cycle; the verdict, slot write-back
// and statistics update happen in the evaluation state once the result can commit.
// Reset clears the slot valid bits, highest-seen value and statistics at once;
// no clearing pass is needed. A clear request goes through the same accept and evaluation steps.
// A stalled result beat holds the evaluation cycle until the output register frees.
`default_nettype none
module replay_window_checker_top import rwc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output      logic [APB_DATA_W-1:0] prdata,
	output      logic                  pready,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic                  req_type,
	input  wire logic [CTR_W-1:0]      packet_counter,
	input  wire logic [LEN_W-1:0]      sealed_length,
	input  wire logic                  auth_ok,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic [1:0]            verdict,
	output      logic [STAT_W-1:0]     replays_rejected,
	output      logic [STAT_W-1:0]     auth_failures,
	output      logic [STAT_W-1:0]     packets_opened
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} state_t;

	state_t                   state_q;
	logic                     channel_active;
	logic                     in_fire;
	logic                     commit;

	req_t                     req_q;
	logic [CTR_W-1:0]         ctr_q;
	logic                     len_ok_q;
	logic                     auth_q;
	logic                     le_q;
	logic                     old_q;

	logic [CTR_W-1:0]         highest_q;
	logic                     started_q;
	logic [WINDOW_SLOTS-1:0]  slot_vld_q;
	logic                     out_valid_q;
	verdict_t                 verdict_q;

	logic [CTR_W-1:0]         ctr_diff;
	logic [SLOT_LOG2-1:0]     slot_idx;
	logic [CTR_W-1:0]         rd_data;
	logic [CTR_W-1:0]         slot_val;
	logic                     dup;
	verdict_t                 verdict_d;
	logic                     do_accept;
	logic                     do_clear;
	stat_upd_t                upd;

	rwc_apb_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.channel_active (channel_active)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign commit   = (state_q == ST_EVAL) && (!out_valid_q || !out_stall);
	assign ctr_diff = highest_q - packet_counter;
	assign slot_idx = ctr_q[SLOT_LOG2-1:0];

	rwc_ram #(
		.WIDTH (CTR_W),
		.DEPTH (WINDOW_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (commit && do_accept),
		.waddr (slot_idx),
		.wdata (ctr_q),
		.re    (in_fire),
		.raddr (packet_counter[SLOT_LOG2-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q    <= req_t'(req_type);
			ctr_q    <= packet_counter;
			len_ok_q <= channel_active && (sealed_length >= MIN_SEALED_LEN);
			auth_q   <= auth_ok;
			le_q     <= (packet_counter <= highest_q);
			old_q    <= (ctr_diff[CTR_W-1:SLOT_LOG2] != '0);
		end
	end

	assign slot_val = slot_vld_q[slot_idx] ? rd_data : '0;
	assign dup      = (slot_val == ctr_q);

	always_comb begin
		verdict_d = VERDICT_ACCEPT;
		do_accept = 1'b0;
		do_clear  = 1'b0;
		upd       = '0;
		if (req_q == REQ_CLEAR) begin
			do_clear = 1'b1;
		end else if (!len_ok_q) begin
			verdict_d    = VERDICT_AUTH;
			upd.inc_auth = 1'b1;
		end else if (started_q && le_q && old_q) begin
			verdict_d      = VERDICT_TOO_OLD;
			upd.inc_replay = 1'b1;
		end else if (started_q && le_q && dup) begin
			verdict_d      = VERDICT_DUP;
			upd.inc_replay = 1'b1;
		end else if (!auth_q) begin
			verdict_d    = VERDICT_AUTH;
			upd.inc_auth = 1'b1;
		end else begin
			do_accept      = 1'b1;
			upd.inc_accept = 1'b1;
		end
		if (!commit) begin
			upd = '0;
		end
	end

	rwc_stats u_stats (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.replay_cnt (replays_rejected),
		.auth_cnt   (auth_failures),
		.accept_cnt (packets_opened)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			highest_q   <= '0;
			started_q   <= 1'b0;
			slot_vld_q  <= '0;
			out_valid_q <= 1'b0;
			verdict_q   <= VERDICT_ACCEPT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (commit) begin
				out_valid_q <= 1'b1;
				verdict_q   <= verdict_d;
				if (do_clear) begin
					highest_q  <= '0;
					started_q  <= 1'b0;
					slot_vld_q <= '0;
				end else if (do_accept) begin
					if (!started_q || !le_q) begin
						highest_q <= ctr_q;
					end
					started_q            <= 1'b1;
					slot_vld_q[slot_idx] <= 1'b1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule
`default_nettype wire
